### design/touch_serial_receiver_port_assert.svh
// Assertion macros for the checker of the touch serial receiver port.
`ifndef TOUCH_SERIAL_RECEIVER_PORT_ASSERT_SVH
`define TOUCH_SERIAL_RECEIVER_PORT_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define TSRP_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define TSRP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`define TSRP_ASSERT_AFTER2(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> ##2 (cons)) \
		else $error(msg);

`endif

### design/tsrp_pkg.sv
// Types, codes and constants shared by the touch serial receiver port modules.
package tsrp_pkg;

	// Field widths.
	localparam int CLOCK_W   = 28;
	localparam int NOMINAL_W = 20;
	localparam int TOL_W     = 7;
	localparam int LIMIT_W   = 12;
	localparam int SHIFT_W   = 2;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = 28;
	localparam int RELOAD_W  = 16;
	localparam int COORD_W   = 15;

	// Divider widths: the divisor is (reload + 1) times 16 or 32.
	localparam int DIVIDEND_W = CLOCK_W;
	localparam int DIVISOR_W  = RELOAD_W + 6;
	localparam int DIV_CNT_W  = $clog2(DIVIDEND_W + 1);

	// Tolerance check widths.
	localparam int PROD_W   = NOMINAL_W + TOL_W;
	localparam int SCALED_W = DIVIDEND_W + TOL_W;
	localparam logic [TOL_W-1:0] PERCENT_SCALE = 7'd100;

	localparam int FIFO_DEPTH_DEF = 64;

	// Operations.
	localparam logic [1:0] OP_READ  = 2'd0;
	localparam logic [1:0] OP_WRITE = 2'd1;
	localparam logic [1:0] OP_TOUCH = 2'd2;
	localparam logic [1:0] OP_POLL  = 2'd3;

	// Register offsets.
	localparam logic [3:0] OFS_DATA      = 4'h1;
	localparam logic [3:0] OFS_STATUS    = 4'h2;
	localparam logic [3:0] OFS_MODE      = 4'h4;
	localparam logic [3:0] OFS_RELOAD_LO = 4'h6;
	localparam logic [3:0] OFS_RELOAD_HI = 4'h7;

	// Bits and bytes.
	localparam int         MODE_DIV8_BIT  = 4;
	localparam logic [7:0] ERR_FRAMING    = 8'h10;
	localparam logic [7:0] STAT_NOT_EMPTY = 8'h01;
	localparam logic [7:0] STAT_TX_EMPTY  = 8'h02;
	localparam logic [7:0] PACKET_START   = 8'haa;
	localparam logic [7:0] BYTE_FILL      = 8'hff;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] CFG_BAUD_CLK  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_NOMINAL   = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_TOLERANCE = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_X_LIMIT   = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_Y_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SHIFT     = 3'd5;

	// Configuration reset values.
	localparam logic [CLOCK_W-1:0]   RST_BAUD_CLK  = '0;
	localparam logic [NOMINAL_W-1:0] RST_NOMINAL   = 20'd38400;
	localparam logic [TOL_W-1:0]     RST_TOLERANCE = 7'd5;
	localparam logic [LIMIT_W-1:0]   RST_X_LIMIT   = 12'd239;
	localparam logic [LIMIT_W-1:0]   RST_Y_LIMIT   = 12'd207;
	localparam logic [SHIFT_W-1:0]   RST_SHIFT     = 2'd2;

	// Byte slots of a queued burst.
	localparam logic [2:0] SLOT_START  = 3'd0;
	localparam logic [2:0] SLOT_X_HI   = 3'd1;
	localparam logic [2:0] SLOT_X_LO   = 3'd2;
	localparam logic [2:0] SLOT_Y_HI   = 3'd3;
	localparam logic [2:0] SLOT_Y_LO   = 3'd4;
	localparam logic [2:0] SLOT_PRESS  = 3'd5;
	localparam logic [2:0] SLOT_ERR_LAST = 3'd1;

	typedef struct packed {
		logic [1:0]         operation;
		logic [3:0]         reg_offset;
		logic [7:0]         write_data;
		logic signed [15:0] touch_x;
		logic signed [15:0] touch_y;
		logic               pressed;
	} item_t;

	typedef struct packed {
		logic [7:0] read_data;
		logic       irq;
	} result_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_POP,
		ST_DIV,
		ST_RATE_A,
		ST_RATE_B,
		ST_RATE_C,
		ST_PUSH,
		ST_RESP
	} ctrl_state_t;

	typedef struct packed {
		logic       capture;
		logic       load_result;
		logic       mem_pop;
		logic       load_pop;
		logic       reg_write;
		logic       div_start;
		logic       rate_mul;
		logic       rate_scale;
		logic       rate_decide;
		logic       push;
		logic [2:0] push_slot;
	} dp_cmd_t;

	typedef struct packed {
		logic [1:0] operation;
		logic       pop_ok;
		logic       div_done;
		logic       rate_ok;
	} dp_stat_t;

endpackage

### design/tsrp_div.sv
// Restoring divider that produces one quotient bit per cycle.
module tsrp_div (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic [tsrp_pkg::DIVIDEND_W-1:0]    dividend,
	input  logic [tsrp_pkg::DIVISOR_W-1:0]     divisor,
	output logic                               done,
	output logic [tsrp_pkg::DIVIDEND_W-1:0]    quotient
);
	import tsrp_pkg::*;

	logic [DIVISOR_W-1:0]  rem_q;
	logic [DIVISOR_W-1:0]  divisor_q;
	logic [DIVIDEND_W-1:0] quo_q;
	logic [DIV_CNT_W-1:0]  cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [DIVISOR_W:0]    trial;
	logic [DIVISOR_W:0]    diff;
	logic                  ge;

	// The partial remainder stays below the divisor, so the trial fits one extra bit.
	assign trial = {rem_q, quo_q[DIVIDEND_W-1]};
	assign ge    = trial >= {1'b0, divisor_q};
	assign diff  = trial - {1'b0, divisor_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= run_q && (cnt_q == DIV_CNT_W'(1));
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= DIV_CNT_W'(DIVIDEND_W);
			end else if (run_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q     <= '0;
			quo_q     <= dividend;
			divisor_q <= divisor;
		end else if (run_q) begin
			rem_q <= ge ? diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
			quo_q <= {quo_q[DIVIDEND_W-2:0], ge};
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

### design/tsrp_ctrl.sv
// Controller state machine that sequences each transaction through the datapath.
module tsrp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  tsrp_pkg::dp_stat_t stat,
	output tsrp_pkg::dp_cmd_t  cmd,
	output logic               busy,
	output logic               done
);
	import tsrp_pkg::*;

	ctrl_state_t state_q, state_d;
	logic [2:0]  cnt_q, cnt_d;
	logic [2:0]  last_slot;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	// A good baud rate queues a full packet, a bad one only two fill bytes.
	assign last_slot = stat.rate_ok ? SLOT_PRESS : SLOT_ERR_LAST;

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					cmd.capture = 1'b1;
					state_d     = ST_DECODE;
				end
			end
			ST_DECODE: begin
				priority if (stat.operation == OP_READ && stat.pop_ok) begin
					cmd.mem_pop = 1'b1;
					state_d     = ST_POP;
				end else if (stat.operation == OP_TOUCH) begin
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end else begin
					cmd.load_result = 1'b1;
					cmd.reg_write   = (stat.operation == OP_WRITE);
					state_d         = ST_RESP;
				end
			end
			ST_POP: begin
				cmd.load_pop = 1'b1;
				state_d      = ST_RESP;
			end
			ST_DIV: begin
				if (stat.div_done) begin
					state_d = ST_RATE_A;
				end
			end
			ST_RATE_A: begin
				cmd.rate_mul = 1'b1;
				state_d      = ST_RATE_B;
			end
			ST_RATE_B: begin
				cmd.rate_scale = 1'b1;
				state_d        = ST_RATE_C;
			end
			ST_RATE_C: begin
				cmd.rate_decide = 1'b1;
				cnt_d           = SLOT_START;
				state_d         = ST_PUSH;
			end
			ST_PUSH: begin
				cmd.push      = 1'b1;
				cmd.push_slot = cnt_q;
				if (cnt_q == last_slot) begin
					cmd.load_result = 1'b1;
					state_d         = ST_RESP;
				end else begin
					cnt_d = cnt_q + 3'd1;
				end
			end
			ST_RESP: begin
				state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_RESP);

endmodule

### design/tsrp_dp.sv
// Datapath: configuration, port registers, receive FIFO, baud check and result.
module tsrp_dp #(
	parameter int FIFO_DEPTH = tsrp_pkg::FIFO_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  tsrp_pkg::item_t                   item,
	input  logic                              cfg_valid,
	input  logic [tsrp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tsrp_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  tsrp_pkg::dp_cmd_t                 cmd,
	output tsrp_pkg::dp_stat_t                stat,
	output tsrp_pkg::result_t                 result
);
	import tsrp_pkg::*;

	localparam int PTR_W = $clog2(FIFO_DEPTH);

	// Configuration registers.
	logic [CLOCK_W-1:0]   baud_clk_q;
	logic [NOMINAL_W-1:0] nominal_q;
	logic [TOL_W-1:0]     tol_q;
	logic [LIMIT_W-1:0]   x_limit_q;
	logic [LIMIT_W-1:0]   y_limit_q;
	logic [SHIFT_W-1:0]   shift_q;

	// Port state.
	logic [7:0]          mode_q;
	logic [RELOAD_W-1:0] reload_q;
	logic [7:0]          err_q;
	logic [PTR_W-1:0]    rptr_q;
	logic [PTR_W-1:0]    wptr_q;
	logic [7:0]          mem [FIFO_DEPTH];
	logic [7:0]          mem_q;

	// Transaction payload.
	item_t               item_q;
	logic [PROD_W-1:0]   prod_q;
	logic [DIVIDEND_W-1:0] diff_q;
	logic [SCALED_W-1:0] scaled_q;
	logic                ok_q;
	logic [7:0]          rd_q;
	logic                irq_q;

	logic [PTR_W-1:0]    rptr_nxt;
	logic [PTR_W-1:0]    wptr_nxt;
	logic [PTR_W:0]      occ_wide;
	logic [PTR_W-1:0]    occ;
	logic [1:0]          occ_code;
	logic                not_empty;
	logic                full;
	logic [7:0]          status_byte;
	logic [RELOAD_W:0]   reload_p1;
	logic [DIVISOR_W-1:0] divisor;
	logic                div_done;
	logic [DIVIDEND_W-1:0] quotient;
	logic                rate_good;
	logic [LIMIT_W-1:0]  cx;
	logic [LIMIT_W-1:0]  cy;
	logic [COORD_W-1:0]  tx;
	logic [COORD_W-1:0]  ty;
	logic [7:0]          fifo_wr_byte;
	logic [7:0]          direct_rd;
	logic                direct_irq;

	// FIFO pointers wrap at the depth, which need not be a power of two.
	assign rptr_nxt = (rptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rptr_q + PTR_W'(1);
	assign wptr_nxt = (wptr_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wptr_q + PTR_W'(1);
	assign not_empty = (rptr_q != wptr_q);
	assign full      = (wptr_nxt == rptr_q);
	assign occ_wide  = {1'b0, wptr_q} + (PTR_W + 1)'(FIFO_DEPTH) - {1'b0, rptr_q};
	assign occ       = (wptr_q >= rptr_q) ? (wptr_q - rptr_q) : occ_wide[PTR_W-1:0];

	always_comb begin
		if (occ <= PTR_W'(1)) begin
			occ_code = 2'd0;
		end else if (occ >= PTR_W'(4)) begin
			occ_code = 2'd3;
		end else begin
			occ_code = occ[1:0] - 2'd1;
		end
	end

	assign status_byte = STAT_TX_EMPTY | (not_empty ? STAT_NOT_EMPTY : 8'h00)
		| {occ_code, 6'b0} | err_q;

	// Divisor is 2 * (8 or 16) * (reload + 1).
	assign reload_p1 = {1'b0, reload_q} + (RELOAD_W + 1)'(1);
	assign divisor   = mode_q[MODE_DIV8_BIT] ? {1'b0, reload_p1, 4'b0} : {reload_p1, 5'b0};

	tsrp_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.div_start),
		.dividend (baud_clk_q),
		.divisor  (divisor),
		.done     (div_done),
		.quotient (quotient)
	);

	// The band test slack >= |rate - nominal| is done without a divide by 100:
	// floor(P / 100) >= d holds exactly when P >= 100 * d.
	assign rate_good = (quotient == '0) || ({{(SCALED_W - PROD_W){1'b0}}, prod_q} >= scaled_q);

	// Coordinate clamp into 0 .. limit.
	always_comb begin
		if (item_q.touch_x[15]) begin
			cx = '0;
		end else if (item_q.touch_x[14:0] > {3'b0, x_limit_q}) begin
			cx = x_limit_q;
		end else begin
			cx = item_q.touch_x[LIMIT_W-1:0];
		end
		if (item_q.touch_y[15]) begin
			cy = '0;
		end else if (item_q.touch_y[14:0] > {3'b0, y_limit_q}) begin
			cy = y_limit_q;
		end else begin
			cy = item_q.touch_y[LIMIT_W-1:0];
		end
	end

	assign tx = {3'b0, cx} << shift_q;
	assign ty = {3'b0, cy} << shift_q;

	always_comb begin
		if (!ok_q) begin
			fifo_wr_byte = BYTE_FILL;
		end else begin
			unique case (cmd.push_slot)
				SLOT_START: fifo_wr_byte = PACKET_START;
				SLOT_X_HI:  fifo_wr_byte = {1'b0, tx[13:7]};
				SLOT_X_LO:  fifo_wr_byte = {1'b0, tx[6:0]};
				SLOT_Y_HI:  fifo_wr_byte = {1'b0, ty[13:7]};
				SLOT_Y_LO:  fifo_wr_byte = {1'b0, ty[6:0]};
				default:    fifo_wr_byte = {7'b0, item_q.pressed};
			endcase
		end
	end

	// Result of every transaction that does not pop a byte.
	always_comb begin
		direct_rd  = 8'h00;
		direct_irq = 1'b0;
		unique case (item_q.operation)
			OP_READ: begin
				if (item_q.reg_offset == OFS_DATA) begin
					direct_rd = BYTE_FILL;
				end else if (item_q.reg_offset == OFS_STATUS) begin
					direct_rd = status_byte;
				end
			end
			OP_TOUCH: direct_irq = 1'b1;
			OP_POLL:  direct_irq = not_empty;
			default:  direct_irq = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			baud_clk_q <= RST_BAUD_CLK;
			nominal_q  <= RST_NOMINAL;
			tol_q      <= RST_TOLERANCE;
			x_limit_q  <= RST_X_LIMIT;
			y_limit_q  <= RST_Y_LIMIT;
			shift_q    <= RST_SHIFT;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				CFG_BAUD_CLK:  baud_clk_q <= cfg_data[CLOCK_W-1:0];
				CFG_NOMINAL:   nominal_q  <= cfg_data[NOMINAL_W-1:0];
				CFG_TOLERANCE: tol_q      <= cfg_data[TOL_W-1:0];
				CFG_X_LIMIT:   x_limit_q  <= cfg_data[LIMIT_W-1:0];
				CFG_Y_LIMIT:   y_limit_q  <= cfg_data[LIMIT_W-1:0];
				CFG_SHIFT:     shift_q    <= cfg_data[SHIFT_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= '0;
			reload_q <= '0;
			err_q    <= '0;
			rptr_q   <= '0;
			wptr_q   <= '0;
		end else begin
			if (cmd.reg_write) begin
				unique case (item_q.reg_offset)
					OFS_STATUS:    err_q          <= err_q & item_q.write_data;
					OFS_MODE:      mode_q         <= item_q.write_data;
					OFS_RELOAD_LO: reload_q[7:0]  <= item_q.write_data;
					OFS_RELOAD_HI: reload_q[15:8] <= item_q.write_data;
					default: ;
				endcase
			end
			if (cmd.rate_decide && !rate_good) begin
				err_q <= err_q | ERR_FRAMING;
			end
			if (cmd.mem_pop) begin
				rptr_q <= rptr_nxt;
			end
			if (cmd.push && !full) begin
				wptr_q <= wptr_nxt;
			end
		end
	end

	// Receive store: one write port for pushes, one registered read port for pops.
	always_ff @(posedge clk) begin
		if (cmd.push && !full) begin
			mem[wptr_q] <= fifo_wr_byte;
		end
		if (cmd.mem_pop) begin
			mem_q <= mem[rptr_q];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			item_q <= item;
		end
		if (cmd.rate_mul) begin
			prod_q <= nominal_q * tol_q;
			diff_q <= (quotient >= {{(DIVIDEND_W - NOMINAL_W){1'b0}}, nominal_q})
				? quotient - {{(DIVIDEND_W - NOMINAL_W){1'b0}}, nominal_q}
				: {{(DIVIDEND_W - NOMINAL_W){1'b0}}, nominal_q} - quotient;
		end
		if (cmd.rate_scale) begin
			scaled_q <= diff_q * PERCENT_SCALE;
		end
		if (cmd.rate_decide) begin
			ok_q <= rate_good;
		end
		if (cmd.load_pop) begin
			rd_q  <= mem_q;
			irq_q <= 1'b0;
		end else if (cmd.load_result) begin
			rd_q  <= direct_rd;
			irq_q <= direct_irq;
		end
	end

	assign stat.operation = item_q.operation;
	assign stat.pop_ok    = (item_q.reg_offset == OFS_DATA) && not_empty;
	assign stat.div_done  = div_done;
	assign stat.rate_ok   = ok_q;

	assign result.read_data = rd_q;
	assign result.irq       = irq_q;

endmodule

### design/touch_serial_receiver_port.sv
// Top level of the touch serial receiver port: controller, datapath and ports.
//
// A transaction is taken when start is high while busy is low, and its single
// result appears on result for exactly one cycle with done high; the receiver
// cannot stall it, so sample result whenever done is high. Bus writes, polls
// and reads of status or of an empty data register go from decode straight
// to the response state and then back to idle. A read that pops a byte adds
// a pop state for the registered read of the receive store. A touch event
// runs a one-bit-per-cycle divide of the configured clock by the baud
// divisor, which yields 28 quotient bits and then a registered done flag.
// The tolerance arithmetic follows in three steps (multiply, scale, decide),
// and then each byte that it queues is pushed in turn: a six-byte packet, or
// only two fill bytes for an out-of-band rate. Every touch event raises irq;
// a poll raises irq when the receive FIFO holds data. The FIFO keeps at most
// FIFO_DEPTH - 1 bytes and silently drops bytes pushed while it is full.
// Configuration registers are written through the cfg port, which is always
// ready; write them only while busy is low.
module touch_serial_receiver_port #(
	parameter int FIFO_DEPTH = tsrp_pkg::FIFO_DEPTH_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	output logic                              busy,
	input  tsrp_pkg::item_t                   item,
	output logic                              done,
	output tsrp_pkg::result_t                 result,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [tsrp_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [tsrp_pkg::CFG_DATA_W-1:0]   cfg_data
);
	import tsrp_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	// The configuration registers take a write in any cycle.
	assign cfg_ready = 1'b1;

	// The controller steps each transaction through decode, then a pop or a touch event's divide, check and push.
	tsrp_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// The datapath holds the configuration and port registers, the receive store and the divider.
	tsrp_dp #(
		.FIFO_DEPTH (FIFO_DEPTH)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

### design/tsrp_checker.sv
// Port-level checker for the touch serial receiver port and its bind.
`include "touch_serial_receiver_port_assert.svh"

module tsrp_checker (
	input logic              clk,
	input logic              arst_n,
	input logic              start,
	input logic              busy,
	input logic              done,
	input tsrp_pkg::item_t   item,
	input tsrp_pkg::result_t result
);
	import tsrp_pkg::*;

	`TSRP_ASSERT_NEXT(a_accept_busy, clk, arst_n, start && !busy, busy, "accepted transaction did not raise busy")
	`TSRP_ASSERT_SAME(a_done_in_busy, clk, arst_n, done, busy, "done strobe outside a transaction")
	`TSRP_ASSERT_NEXT(a_done_single, clk, arst_n, done, !done && !busy, "result strobe longer than one cycle")
	`TSRP_ASSERT_AFTER2(a_write_result, clk, arst_n, start && !busy && item.operation == OP_WRITE, done && result.read_data == 8'h00 && !result.irq, "bus write result wrong or late")
	`TSRP_ASSERT_AFTER2(a_touch_long, clk, arst_n, start && !busy && item.operation == OP_TOUCH, !done, "touch event finished too early")

endmodule

bind touch_serial_receiver_port tsrp_checker u_tsrp_checker (.*);

### verif/touch_serial_receiver_port_test.sv
// Self-checking testbench for the touch serial receiver port: directed and random transactions.
module touch_serial_receiver_port_test;
	timeunit 1ns;
	timeprecision 1ps;

	import tsrp_pkg::*;

	localparam int PORT_DEPTH = FIFO_DEPTH_DEF;
	// Watchdog limit for the whole run, set with a wide margin over the slowest correct run.
	localparam int unsigned CYCLE_LIMIT = 600000;
	// Cycles allowed after the last result before the verdict.
	localparam int DRAIN_CYCLES = 60;

	// Tracks the port's registers and receive FIFO, works out the response each
	// accepted transaction must produce and compares the responses that come back.
	class rx_port_scoreboard;
		logic [CLOCK_W-1:0]   baud_clk;
		logic [NOMINAL_W-1:0] nominal_baud;
		logic [TOL_W-1:0]     tolerance_pct;
		logic [LIMIT_W-1:0]   x_limit;
		logic [LIMIT_W-1:0]   y_limit;
		logic [SHIFT_W-1:0]   coord_shift;
		logic [7:0]           mode_byte;
		logic [7:0]           error_bits;
		logic [RELOAD_W-1:0]  reload;
		logic [7:0]           rx_bytes[$];
		result_t              expected_responses[$];
		int                   capacity;
		int                   errors;
		int                   transactions;
		int                   checked;
		int                   packets;
		int                   framing;
		int                   dropped;

		function new(int depth);
			capacity = depth - 1;
			baud_clk = RST_BAUD_CLK;
			nominal_baud = RST_NOMINAL;
			tolerance_pct = RST_TOLERANCE;
			x_limit = RST_X_LIMIT;
			y_limit = RST_Y_LIMIT;
			coord_shift = RST_SHIFT;
			mode_byte = '0;
			error_bits = '0;
			reload = '0;
			errors = 0;
			transactions = 0;
			checked = 0;
			packets = 0;
			framing = 0;
			dropped = 0;
		endfunction

		function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
			case (idx)
			CFG_BAUD_CLK: baud_clk = val[CLOCK_W-1:0];
			CFG_NOMINAL: nominal_baud = val[NOMINAL_W-1:0];
			CFG_TOLERANCE: tolerance_pct = val[TOL_W-1:0];
			CFG_X_LIMIT: x_limit = val[LIMIT_W-1:0];
			CFG_Y_LIMIT: y_limit = val[LIMIT_W-1:0];
			CFG_SHIFT: coord_shift = val[SHIFT_W-1:0];
			default: ;
			endcase
		endfunction

		function void queue_rx_byte(logic [7:0] b);
			if (rx_bytes.size() < capacity) begin
				rx_bytes.push_back(b);
			end else begin
				dropped++;
			end
		endfunction

		// A zero clock or a rate that truncates to zero always passes the band check.
		function bit rate_in_band();
			longint unsigned divisor;
			longint unsigned rate;
			longint unsigned slack;
			longint unsigned nom;
			divisor = (mode_byte[MODE_DIV8_BIT] ? 64'd16 : 64'd32) * (64'(reload) + 64'd1);
			if (baud_clk == '0)
				return 1'b1;
			rate = 64'(baud_clk) / divisor;
			if (rate == 0)
				return 1'b1;
			nom = 64'(nominal_baud);
			slack = nom * 64'(tolerance_pct) / 64'd100;
			return (rate + slack >= nom) && (rate <= nom + slack);
		endfunction

		function logic [LIMIT_W-1:0] clamp(logic signed [15:0] raw, logic [LIMIT_W-1:0] lim);
			int v;
			v = raw;
			if (v < 0)
				return '0;
			if (v > int'(lim))
				return lim;
			return v[LIMIT_W-1:0];
		endfunction

		function void note_transaction(item_t it);
			result_t            r;
			logic [COORD_W-1:0] tx;
			logic [COORD_W-1:0] ty;
			logic [1:0]         code;
			int                 n;
			r = '0;
			transactions++;
			case (it.operation)
			OP_READ: begin
				if (it.reg_offset == OFS_DATA) begin
					if (rx_bytes.size() != 0)
						r.read_data = rx_bytes.pop_front();
					else
						r.read_data = BYTE_FILL;
				end else if (it.reg_offset == OFS_STATUS) begin
					n = rx_bytes.size();
					code = (n <= 1) ? 2'd0 : (n >= 4) ? 2'd3 : 2'(n - 1);
					r.read_data = STAT_TX_EMPTY | error_bits | {code, 6'b0};
					if (n != 0)
						r.read_data = r.read_data | STAT_NOT_EMPTY;
				end
			end
			OP_WRITE: begin
				if (it.reg_offset == OFS_STATUS)
					error_bits = error_bits & it.write_data;
				else if (it.reg_offset == OFS_MODE)
					mode_byte = it.write_data;
				else if (it.reg_offset == OFS_RELOAD_LO)
					reload[7:0] = it.write_data;
				else if (it.reg_offset == OFS_RELOAD_HI)
					reload[15:8] = it.write_data;
			end
			OP_TOUCH: begin
				if (!rate_in_band()) begin
					error_bits = error_bits | ERR_FRAMING;
					queue_rx_byte(BYTE_FILL);
					queue_rx_byte(BYTE_FILL);
					framing++;
				end else begin
					tx = COORD_W'(clamp(it.touch_x, x_limit)) << coord_shift;
					ty = COORD_W'(clamp(it.touch_y, y_limit)) << coord_shift;
					queue_rx_byte(PACKET_START);
					queue_rx_byte({1'b0, tx[13:7]});
					queue_rx_byte({1'b0, tx[6:0]});
					queue_rx_byte({1'b0, ty[13:7]});
					queue_rx_byte({1'b0, ty[6:0]});
					queue_rx_byte({7'b0, it.pressed});
					packets++;
				end
				r.irq = 1'b1;
			end
			default: begin
				r.irq = (rx_bytes.size() != 0);
			end
			endcase
			expected_responses.push_back(r);
		endfunction

		function void check_response(result_t got);
			result_t want;
			if (expected_responses.size() == 0) begin
				$error("response with no transaction outstanding: read_data %0h irq %0b",
					got.read_data, got.irq);
				errors++;
				return;
			end
			want = expected_responses.pop_front();
			checked++;
			if (got.read_data !== want.read_data) begin
				$error("read_data: expected %0h, actual %0h", want.read_data, got.read_data);
				errors++;
			end
			if (got.irq !== want.irq) begin
				$error("irq: expected %0b, actual %0b", want.irq, got.irq);
				errors++;
			end
		endfunction
	endclass

	logic                  clk;
	logic                  arst_n;
	logic                  start;
	logic                  busy;
	item_t                 item;
	logic                  done;
	result_t               result;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	rx_port_scoreboard sb;
	int unsigned       cycles = 0;
	int                sent = 0;
	bit                idle_en = 1'b0;

	touch_serial_receiver_port #(
		.FIFO_DEPTH(PORT_DEPTH)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.item(item),
		.done(done),
		.result(result),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #4 clk = ~clk;

	// The watchdog: a run that has not finished by now has hung somewhere.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("FAIL touch_serial_receiver_port");
			$finish;
		end
	end

	// Everything the model sees is taken from the pins at the rising edge, where
	// the inputs have been steady since the falling edge. A response is checked
	// before the transaction accepted on the same edge is noted, so a response can
	// never be matched against its own request.
	always @(posedge clk) begin
		if (arst_n) begin
			if (done)
				sb.check_response(result);
			if (start && !busy)
				sb.note_transaction(item);
			if (cfg_valid && cfg_ready)
				sb.write_reg(cfg_index, cfg_data);
		end
	end

	function item_t noise_item();
		item_t it;
		it.operation = 2'($urandom);
		it.reg_offset = 4'($urandom);
		it.write_data = 8'($urandom);
		it.touch_x = 16'($urandom);
		it.touch_y = 16'($urandom);
		it.pressed = 1'($urandom);
		return it;
	endfunction

	// Fields that a bus access ignores are left random.
	function item_t bus_item(logic [1:0] op, logic [3:0] ofs, logic [7:0] wd);
		item_t it;
		it = noise_item();
		it.operation = op;
		it.reg_offset = ofs;
		it.write_data = wd;
		return it;
	endfunction

	function item_t touch_at(logic signed [15:0] x, logic signed [15:0] y, logic p);
		item_t it;
		it = noise_item();
		it.operation = OP_TOUCH;
		it.touch_x = x;
		it.touch_y = y;
		it.pressed = p;
		return it;
	endfunction

	// Coordinates are spread over the whole 16-bit range, around the clamp limit
	// and over the edge values, so both clamps and the pass-through path all hit.
	function logic signed [15:0] pick_coord(logic [LIMIT_W-1:0] lim);
		int v;
		case ($urandom_range(0, 3))
		0: v = int'($urandom_range(0, 65535));
		1: v = int'(lim) + int'($urandom_range(0, 16)) - 8;
		2: begin
			case ($urandom_range(0, 5))
			0: v = 32'h8000;
			1: v = 32'h7fff;
			2: v = 0;
			3: v = -1;
			4: v = int'(lim);
			default: v = int'(lim) + 1;
			endcase
		end
		default: v = int'($urandom_range(0, 4095));
		endcase
		return v[15:0];
	endfunction

	function item_t touch_item();
		return touch_at(pick_coord(sb.x_limit), pick_coord(sb.y_limit), 1'($urandom));
	endfunction

	function logic [3:0] pick_offset();
		if ($urandom_range(0, 9) >= 7)
			return 4'($urandom);
		case ($urandom_range(0, 4))
		0: return OFS_DATA;
		1: return OFS_STATUS;
		2: return OFS_MODE;
		3: return OFS_RELOAD_LO;
		default: return OFS_RELOAD_HI;
		endcase
	endfunction

	// A reload value close to the one that hits the nominal rate, so that touch
	// events land on both sides of the tolerance band.
	function logic [RELOAD_W-1:0] near_reload();
		longint unsigned ideal;
		int              r;
		ideal = 64'(sb.baud_clk) /
			((sb.mode_byte[MODE_DIV8_BIT] ? 64'd16 : 64'd32) * 64'(sb.nominal_baud));
		r = (ideal > 64'd70000) ? 65535 : int'(ideal) - 1;
		r = r + int'($urandom_range(0, 4)) - 2;
		if (r < 0)
			r = 0;
		if (r > 65535)
			r = 65535;
		return r[RELOAD_W-1:0];
	endfunction

	// Presents one transaction and returns at the edge that accepts it. start
	// stays high afterwards, so back-to-back transactions wait on busy alone;
	// while idling, the item lines carry junk.
	task automatic send_item(input item_t it);
		int gap;
		gap = 0;
		if (idle_en && $urandom_range(0, 99) < 33)
			gap = $urandom_range(1, 8);
		repeat (gap) begin
			@(negedge clk);
			start <= 1'b0;
			item <= noise_item();
		end
		@(negedge clk);
		start <= 1'b1;
		item <= it;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sent++;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (cfg_ready !== 1'b1)
			@(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Drops start and waits until every response is in and the port is idle
	// again, plus a short margin, before registers may be touched.
	task automatic wait_port_idle();
		@(negedge clk);
		start <= 1'b0;
		while (sb.expected_responses.size() != 0 || busy !== 1'b0)
			@(negedge clk);
		repeat (4)
			@(negedge clk);
	endtask

	task automatic program_port(input logic [CLOCK_W-1:0] hz, input logic [NOMINAL_W-1:0] nom,
		input logic [TOL_W-1:0] tol, input logic [LIMIT_W-1:0] xl, input logic [LIMIT_W-1:0] yl,
		input logic [SHIFT_W-1:0] sh);
		wait_port_idle();
		write_reg(CFG_BAUD_CLK, CFG_DATA_W'(hz));
		write_reg(CFG_NOMINAL, CFG_DATA_W'(nom));
		write_reg(CFG_TOLERANCE, CFG_DATA_W'(tol));
		write_reg(CFG_X_LIMIT, CFG_DATA_W'(xl));
		write_reg(CFG_Y_LIMIT, CFG_DATA_W'(yl));
		write_reg(CFG_SHIFT, CFG_DATA_W'(sh));
	endtask

	// Random traffic is mostly built from short, meaningful sequences: bursts of
	// touches that fill the FIFO past its limit, bursts of data reads that drain
	// it past empty, baud retuning followed by a touch, and framing error
	// handling through the status register. Single random transactions, unused
	// offsets included, fill the rest.
	task automatic run_random(input int count);
		int                  target;
		int                  k;
		logic [RELOAD_W-1:0] rl;
		logic [1:0]          op;
		target = sent + count;
		while (sent < target) begin
			case ($urandom_range(0, 9))
			0, 1: begin
				k = $urandom_range(4, 40);
				repeat (k)
					send_item(bus_item(OP_READ, OFS_DATA, 8'($urandom)));
				if ($urandom_range(0, 1))
					send_item(bus_item(OP_READ, OFS_STATUS, 8'($urandom)));
			end
			2, 3: begin
				k = $urandom_range(2, 12);
				repeat (k) begin
					send_item(touch_item());
					if ($urandom_range(0, 3) == 0)
						send_item(bus_item(OP_POLL, 4'($urandom), 8'($urandom)));
				end
			end
			4: begin
				send_item(bus_item(OP_WRITE, OFS_MODE, 8'($urandom)));
				rl = ($urandom_range(0, 3) == 0) ? RELOAD_W'($urandom) : near_reload();
				send_item(bus_item(OP_WRITE, OFS_RELOAD_LO, rl[7:0]));
				send_item(bus_item(OP_WRITE, OFS_RELOAD_HI, rl[15:8]));
				send_item(touch_item());
			end
			5: begin
				send_item(bus_item(OP_READ, OFS_STATUS, 8'($urandom)));
				send_item(bus_item(OP_WRITE, OFS_STATUS,
					$urandom_range(0, 1) ? ~ERR_FRAMING : 8'($urandom)));
				send_item(bus_item(OP_READ, OFS_STATUS, 8'($urandom)));
			end
			default: begin
				op = 2'($urandom);
				if (op == OP_TOUCH)
					send_item(touch_item());
				else
					send_item(bus_item(op, pick_offset(), 8'($urandom)));
			end
			endcase
		end
	endtask

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sb = new(PORT_DEPTH);
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed part at the reset settings: with no clock programmed every
		// touch passes the rate check. Empty FIFO reads, unused offsets, both
		// clamps at their extremes and a full packet read back byte by byte.
		send_item(bus_item(OP_READ, OFS_DATA, 8'h00));
		send_item(bus_item(OP_READ, OFS_STATUS, 8'h00));
		send_item(bus_item(OP_POLL, 4'h0, 8'h00));
		send_item(bus_item(OP_READ, 4'h0, 8'h00));
		send_item(bus_item(OP_READ, 4'hf, 8'hff));
		send_item(bus_item(OP_WRITE, 4'hf, 8'hff));
		send_item(touch_at(16'sh8000, 16'sh7fff, 1'b1));
		send_item(bus_item(OP_READ, OFS_STATUS, 8'h00));
		send_item(bus_item(OP_POLL, 4'hf, 8'hff));
		repeat (6)
			send_item(bus_item(OP_READ, OFS_DATA, 8'h00));
		send_item(touch_at(16'sh7fff, -16'sd1, 1'b0));
		send_item(touch_at(16'sd239, 16'sd208, 1'b1));
		send_item(bus_item(OP_WRITE, OFS_MODE, 8'h10));
		send_item(bus_item(OP_WRITE, OFS_STATUS, 8'h00));

		// A real clock with reload zero runs far too fast: the touch must raise
		// the framing error, which is then cleared through the status register.
		program_port(28'd200_000_000, 20'd38400, 7'd5, 12'd239, 12'd207, 2'd2);
		send_item(bus_item(OP_WRITE, OFS_RELOAD_LO, 8'h00));
		send_item(bus_item(OP_WRITE, OFS_RELOAD_HI, 8'h00));
		send_item(touch_at(16'sd100, 16'sd100, 1'b1));
		send_item(bus_item(OP_READ, OFS_STATUS, 8'h00));
		send_item(bus_item(OP_WRITE, OFS_STATUS, ~ERR_FRAMING));
		send_item(bus_item(OP_READ, OFS_STATUS, 8'h00));

		idle_en = 1'b1;
		run_random(170);

		// Largest limits and shift, fastest panel and no tolerance at all.
		program_port(28'd200_000_000, 20'd1_000_000, 7'd0, 12'd4095, 12'd4095, 2'd3);
		run_random(170);

		// Smallest settings; the slowest clock makes every rate truncate to zero.
		// This phase runs without any idling on the request side.
		program_port(28'd1, 20'd1, 7'd100, 12'd0, 12'd0, 2'd0);
		idle_en = 1'b0;
		run_random(170);

		idle_en = 1'b1;
		program_port(CLOCK_W'($urandom_range(1_000_000, 200_000_000)),
			NOMINAL_W'($urandom_range(1200, 1_000_000)), TOL_W'($urandom_range(0, 100)),
			LIMIT_W'($urandom_range(0, 4095)), LIMIT_W'($urandom_range(0, 4095)),
			SHIFT_W'($urandom));
		run_random(170);

		// A tight band where only the divide-by-8 mode can land in range.
		program_port(28'd24_000_000, 20'd115200, 7'd2, 12'd4095, 12'd0, 2'd1);
		run_random(170);

		wait_port_idle();
		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (sb.expected_responses.size() != 0) begin
			$error("%0d responses never arrived", sb.expected_responses.size());
			sb.errors += sb.expected_responses.size();
		end
		$display("Covered %0d transactions under six register settings: %0d packets, %0d framing",
			sb.transactions, sb.packets, sb.framing);
		$display("errors and %0d bytes dropped at a full FIFO; %0d responses checked, %0d errors.",
			sb.dropped, sb.checked, sb.errors);
		if (sb.errors == 0) begin
			$display("PASS touch_serial_receiver_port");
		end else begin
			$display("FAIL touch_serial_receiver_port");
		end
		$finish;
	end
endmodule
